@@ rtl/thi_pkg.sv @@
// Shared types, constants and state codes for the triangle height-field interpolator.
package thi_pkg;

    // Field widths of the input and result words
    localparam int COORD_W  = 24;
    localparam int HEIGHT_W = 24;
    localparam int VIDX_W   = 12;
    localparam int FACE_W   = 13;

    // Configuration register widths and reset values
    localparam int CCNT_W  = 6;
    localparam int CSIZE_W = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam logic [CCNT_W-1:0]  CELLS_ACROSS_RST = 6'd16;
    localparam logic [CCNT_W-1:0]  CELLS_DOWN_RST   = 6'd16;
    localparam logic [CSIZE_W-1:0] CELL_WIDTH_RST   = 10'd32;
    localparam logic [CSIZE_W-1:0] CELL_HEIGHT_RST  = 10'd32;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_ACROSS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_DOWN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT  = 2'd3;

    // Input modes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Width of a corner address before the store range check
    localparam int CADDR_W = 13;

    // Parameter defaults
    localparam int VERTICES_PER_SIDE_DEF = 64;
    localparam int COORD_FRAC_BITS_DEF   = 8;

    typedef struct packed {
        logic                       mode;
        logic [VIDX_W-1:0]          vertex_index;
        logic signed [HEIGHT_W-1:0] vertex_height;
        logic [COORD_W-1:0]         query_x;
        logic [COORD_W-1:0]         query_y;
    } in_item_t;

    typedef struct packed {
        logic [FACE_W-1:0]          face_index;
        logic signed [HEIGHT_W-1:0] height;
        logic                       outside;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_SEL,
        ST_RD,
        ST_MLO,
        ST_MHI,
        ST_FLUSH,
        ST_FDIV,
        ST_FWAIT,
        ST_OUT
    } state_t;

endpackage

@@ rtl/triangle_heightfield_interpolator.sv @@
// Top level: vertex height store and barycentric height query sequencer.
//
//  channel  | ports                                   | moves
//  ---------+-----------------------------------------+--------------------------------
//  input    | s_valid  s_ready  s_data                | vertex write or query word
//  result   | m_valid  m_ready  m_data                | face, height, outside word
//  config   | cfg_valid cfg_ready cfg_index cfg_data  | register write word
//
// A vertex write leaves the sequencer idle. A query raises m_valid when its result
// is loaded (a point outside the grid skips the corner steps, and a zero register
// skips the dividers too), and s_ready comes back in the same cycle: two 24-step
// coordinate dividers run side by side, three corners are read one after the other
// from the single read port of the store and weighted by one shared multiplier in
// two halves, and a 24-step divider scales by the cell area.
// Reset is synchronous, active low; the vertex store is not cleared.
// The next word is taken while a result waits on m_ready; a stalled result
// only holds the sequencer in its output step.
module triangle_heightfield_interpolator #(
    parameter int VERTICES_PER_SIDE = thi_pkg::VERTICES_PER_SIDE_DEF,
    parameter int COORD_FRAC_BITS   = thi_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  thi_pkg::in_item_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output thi_pkg::out_item_t                  m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [thi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [thi_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int F      = COORD_FRAC_BITS;
    localparam int DEPTH  = VERTICES_PER_SIDE * VERTICES_PER_SIDE;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = thi_pkg::COORD_W;
    localparam int HW     = thi_pkg::HEIGHT_W;
    localparam int NW     = thi_pkg::CCNT_W;
    localparam int SW     = thi_pkg::CSIZE_W;
    localparam int AD_W   = thi_pkg::CADDR_W;
    localparam int WQ_W   = SW + F;
    localparam int D_W    = 2 * SW + F;
    localparam int LO_W   = (D_W + 1) / 2;
    localparam int HI_W   = D_W - LO_W;
    localparam int PROD_W = HW + LO_W + 1;
    localparam int SUM_W  = HW + D_W + 2;
    localparam int FB_W   = thi_pkg::FACE_W - 1;

    thi_pkg::state_t state_reg, state_next;

    logic [NW-1:0] ca_reg, ca_next, cd_reg, cd_next;
    logic [SW-1:0] cw_reg, cw_next, ch_reg, ch_next;

    logic [NW-1:0]   col_reg, col_next, row_reg, row_next;
    logic [WQ_W-1:0] u_reg, u_next, v_reg, v_next;
    logic [D_W-1:0]  p_reg, p_next, q_reg, q_next, d_reg, d_next;
    logic [AD_W-1:0] base_reg, base_next;
    logic [FB_W-1:0] fb_reg, fb_next;
    logic [D_W-1:0]  w_reg [3];
    logic [D_W-1:0]  w_next [3];
    logic [AD_W-1:0] a_reg [3];
    logic [AD_W-1:0] a_next [3];
    logic [1:0]      k_reg, k_next;

    logic signed [HW-1:0]     h_reg, h_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                     pvld_reg, pvld_next;
    logic                     phi_reg, phi_next;
    logic signed [SUM_W-1:0]  acc_reg, acc_next;
    logic                     neg_reg, neg_next;

    logic [thi_pkg::FACE_W-1:0] face_reg, face_next;
    logic signed [HW-1:0]       hgt_reg, hgt_next;
    logic                       outs_reg, outs_next;

    logic               m_valid_reg, m_valid_next;
    thi_pkg::out_item_t m_data_reg, m_data_next;

    // divider and memory hookup
    logic            xdiv_start, xdiv_done, ydiv_done, fdiv_start, fdiv_done;
    logic [CW-1:0]   x_quo, y_quo;
    logic [WQ_W-1:0] x_rem, y_rem;
    logic [WQ_W-1:0] wq, hq;
    logic [SUM_W-1:0] f_dvd;
    logic [HW-1:0]   f_quo;
    logic [D_W-1:0]  f_rem;
    logic            ram_we;
    logic [AW-1:0]   ram_raddr;
    logic [HW-1:0]   ram_rdata;

    logic                    in_acc, cfg_zero;
    logic signed [HW-1:0]    mul_a;
    logic [LO_W-1:0]         mul_b;
    logic signed [PROD_W-1:0] mul_p;

    assign s_ready   = (state_reg == thi_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_valid && s_ready;
    assign cfg_zero  = (ca_reg == '0) || (cd_reg == '0) || (cw_reg == '0) || (ch_reg == '0);

    assign wq = WQ_W'(cw_reg) << F;
    assign hq = WQ_W'(ch_reg) << F;

    assign xdiv_start = in_acc && (s_data.mode == thi_pkg::MODE_QUERY) && !cfg_zero;
    assign fdiv_start = (state_reg == thi_pkg::ST_FDIV);
    assign f_dvd      = acc_reg[SUM_W-1] ? SUM_W'(-acc_reg) : SUM_W'(acc_reg);

    assign ram_we = in_acc && (s_data.mode == thi_pkg::MODE_WRITE) &&
                    (32'(s_data.vertex_index) < DEPTH);
    assign ram_raddr = AW'(a_reg[k_reg]);

    thi_div #(.DW(CW), .VW(WQ_W), .QW(CW)) u_xdiv (
        .aclk(aclk), .aresetn(aresetn), .start(xdiv_start),
        .dividend(s_data.query_x), .divisor(wq),
        .done(xdiv_done), .quotient(x_quo), .remainder(x_rem)
    );

    thi_div #(.DW(CW), .VW(WQ_W), .QW(CW)) u_ydiv (
        .aclk(aclk), .aresetn(aresetn), .start(xdiv_start),
        .dividend(s_data.query_y), .divisor(hq),
        .done(ydiv_done), .quotient(y_quo), .remainder(y_rem)
    );

    thi_div #(.DW(SUM_W), .VW(D_W), .QW(HW)) u_fdiv (
        .aclk(aclk), .aresetn(aresetn), .start(fdiv_start),
        .dividend(f_dvd), .divisor(d_reg),
        .done(fdiv_done), .quotient(f_quo), .remainder(f_rem)
    );

    thi_ram #(.WIDTH(HW), .DEPTH(DEPTH)) u_store (
        .aclk(aclk), .we(ram_we), .waddr(AW'(s_data.vertex_index)),
        .wdata(s_data.vertex_height), .raddr(ram_raddr), .rdata(ram_rdata)
    );

    // shared multiplier: corner height times one half of its weight
    assign mul_a = (state_reg == thi_pkg::ST_MLO) ?
                   ((32'(a_reg[k_reg]) < DEPTH) ? $signed(ram_rdata) : '0) : h_reg;
    assign mul_b = (state_reg == thi_pkg::ST_MLO) ? w_reg[k_reg][LO_W-1:0] :
                   LO_W'(w_reg[k_reg][D_W-1:LO_W]);
    assign mul_p = PROD_W'(mul_a) * $signed({1'b0, mul_b});

    // sequencer and datapath next state
    always_comb begin
        logic                  lower;
        logic [AD_W-1:0]       rw, st, a_tl, a_bl, a_tr, a_br;
        logic signed [SUM_W-1:0] addend;

        state_next = state_reg;
        ca_next = ca_reg; cd_next = cd_reg; cw_next = cw_reg; ch_next = ch_reg;
        col_next = col_reg; row_next = row_reg; u_next = u_reg; v_next = v_reg;
        p_next = p_reg; q_next = q_reg; d_next = d_reg;
        base_next = base_reg; fb_next = fb_reg;
        for (int i = 0; i < 3; i++) begin
            w_next[i] = w_reg[i];
            a_next[i] = a_reg[i];
        end
        k_next = k_reg;
        h_next = h_reg;
        prod_next = prod_reg;
        pvld_next = 1'b0;
        phi_next = phi_reg;
        neg_next = neg_reg;
        face_next = face_reg; hgt_next = hgt_reg; outs_next = outs_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next = m_data_reg;

        lower = ({1'b0, p_reg} + {1'b0, q_reg}) > {1'b0, d_reg};
        rw    = AD_W'(row_reg);
        st    = AD_W'(cd_reg) + 1'b1;
        a_tl  = base_reg + rw;
        a_bl  = a_tl + 1'b1;
        a_tr  = a_tl + st;
        a_br  = a_tr + 1'b1;

        // accumulate the product from the previous cycle
        addend = phi_reg ? (SUM_W'(prod_reg) <<< LO_W) : SUM_W'(prod_reg);
        acc_next = pvld_reg ? acc_reg + addend : acc_reg;

        // configuration writes
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                thi_pkg::REG_CELLS_ACROSS: ca_next = cfg_data[NW-1:0];
                thi_pkg::REG_CELLS_DOWN:   cd_next = cfg_data[NW-1:0];
                thi_pkg::REG_CELL_WIDTH:   cw_next = cfg_data[SW-1:0];
                thi_pkg::REG_CELL_HEIGHT:  ch_next = cfg_data[SW-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            thi_pkg::ST_IDLE: begin
                if (in_acc && (s_data.mode == thi_pkg::MODE_QUERY)) begin
                    if (cfg_zero) begin
                        face_next  = '0;
                        hgt_next   = '0;
                        outs_next  = 1'b1;
                        state_next = thi_pkg::ST_OUT;
                    end else begin
                        state_next = thi_pkg::ST_DIV;
                    end
                end
            end
            thi_pkg::ST_DIV: begin
                if (xdiv_done && ydiv_done) begin
                    if ((x_quo >= CW'(ca_reg)) || (y_quo >= CW'(cd_reg))) begin
                        face_next  = '0;
                        hgt_next   = '0;
                        outs_next  = 1'b1;
                        state_next = thi_pkg::ST_OUT;
                    end else begin
                        col_next   = x_quo[NW-1:0];
                        row_next   = y_quo[NW-1:0];
                        u_next     = x_rem;
                        v_next     = y_rem;
                        state_next = thi_pkg::ST_MUL;
                    end
                end
            end
            thi_pkg::ST_MUL: begin
                p_next    = D_W'(u_reg) * D_W'(ch_reg);
                q_next    = D_W'(v_reg) * D_W'(cw_reg);
                d_next    = (D_W'(cw_reg) * D_W'(ch_reg)) << F;
                base_next = AD_W'(col_reg) * (AD_W'(cd_reg) + 1'b1);
                fb_next   = FB_W'(col_reg) * FB_W'(cd_reg) + FB_W'(row_reg);
                state_next = thi_pkg::ST_SEL;
            end
            thi_pkg::ST_SEL: begin
                // upper triangle wins on the diagonal
                if (!lower) begin
                    w_next[0] = p_reg;                 a_next[0] = a_tr;
                    w_next[1] = q_reg;                 a_next[1] = a_bl;
                    w_next[2] = d_reg - p_reg - q_reg; a_next[2] = a_tl;
                end else begin
                    w_next[0] = p_reg + q_reg - d_reg; a_next[0] = a_br;
                    w_next[1] = d_reg - p_reg;         a_next[1] = a_bl;
                    w_next[2] = d_reg - q_reg;         a_next[2] = a_tr;
                end
                face_next  = {fb_reg, lower};
                acc_next   = '0;
                k_next     = '0;
                state_next = thi_pkg::ST_RD;
            end
            thi_pkg::ST_RD: begin
                state_next = thi_pkg::ST_MLO;
            end
            thi_pkg::ST_MLO: begin
                h_next     = mul_a;
                prod_next  = mul_p;
                phi_next   = 1'b0;
                pvld_next  = 1'b1;
                state_next = thi_pkg::ST_MHI;
            end
            thi_pkg::ST_MHI: begin
                prod_next = mul_p;
                phi_next  = 1'b1;
                pvld_next = 1'b1;
                if (k_reg == 2'd2) begin
                    state_next = thi_pkg::ST_FLUSH;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = thi_pkg::ST_RD;
                end
            end
            thi_pkg::ST_FLUSH: begin
                state_next = thi_pkg::ST_FDIV;
            end
            thi_pkg::ST_FDIV: begin
                neg_next   = acc_reg[SUM_W-1];
                state_next = thi_pkg::ST_FWAIT;
            end
            thi_pkg::ST_FWAIT: begin
                if (fdiv_done) begin
                    hgt_next   = neg_reg ? -$signed(f_quo) : $signed(f_quo);
                    outs_next  = 1'b0;
                    state_next = thi_pkg::ST_OUT;
                end
            end
            thi_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next.face_index = face_reg;
                    m_data_next.height     = hgt_reg;
                    m_data_next.outside    = outs_reg;
                    state_next = thi_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = thi_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= thi_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            pvld_reg    <= 1'b0;
            ca_reg      <= thi_pkg::CELLS_ACROSS_RST;
            cd_reg      <= thi_pkg::CELLS_DOWN_RST;
            cw_reg      <= thi_pkg::CELL_WIDTH_RST;
            ch_reg      <= thi_pkg::CELL_HEIGHT_RST;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            pvld_reg    <= pvld_next;
            ca_reg      <= ca_next;
            cd_reg      <= cd_next;
            cw_reg      <= cw_next;
            ch_reg      <= ch_next;
        end
        col_reg  <= col_next;  row_reg <= row_next;
        u_reg    <= u_next;    v_reg   <= v_next;
        p_reg    <= p_next;    q_reg   <= q_next;   d_reg <= d_next;
        base_reg <= base_next; fb_reg  <= fb_next;
        for (int i = 0; i < 3; i++) begin
            w_reg[i] <= w_next[i];
            a_reg[i] <= a_next[i];
        end
        k_reg    <= k_next;
        h_reg    <= h_next;
        prod_reg <= prod_next;
        phi_reg  <= phi_next;
        acc_reg  <= acc_next;
        neg_reg  <= neg_next;
        face_reg <= face_next;
        hgt_reg  <= hgt_next;
        outs_reg <= outs_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/thi_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module thi_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/thi_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Requires dividend < divisor * 2**QW.
module thi_div #(
    parameter int DW = 24,
    parameter int VW = 18,
    parameter int QW = 24
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [QW-1:0] quotient,
    output logic [VW-1:0] remainder
);

    localparam int CNT_W = $clog2(QW + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [VW-1:0]    rem_reg, rem_next;
    logic [QW-1:0]    quo_reg, quo_next;
    logic [VW-1:0]    dsr_reg, dsr_next;
    logic [VW+1:0]    diff;

    // trial subtract of the divisor from the shifted partial remainder
    assign diff = {1'b0, rem_reg, quo_reg[QW-1]} - {2'b00, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = VW'(dividend >> QW);
            quo_next  = dividend[QW-1:0];
            dsr_next  = divisor;
        end else if (busy_reg) begin
            if (!diff[VW+1]) begin
                rem_next = diff[VW-1:0];
            end else begin
                rem_next = {rem_reg[VW-2:0], quo_reg[QW-1]};
            end
            quo_next = {quo_reg[QW-2:0], ~diff[VW+1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(QW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ rtl/thi_chk.sv @@
// Port-level checker for the triangle height-field interpolator, with its bind.
module thi_chk (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input thi_pkg::in_item_t              s_data,
    input logic                           m_valid,
    input logic                           m_ready,
    input thi_pkg::out_item_t             m_data,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic [thi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [thi_pkg::CFG_DATA_W-1:0] cfg_data
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // an outside point carries zero face and height
    a_outside_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.outside |-> (m_data.face_index == '0) && (m_data.height == '0))
        else $error("outside result with nonzero face or height");

    // no result appears in the cycle right after an accepted word
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result appeared one cycle after input");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind triangle_heightfield_interpolator thi_chk u_thi_chk (.*);

@@ tb/thi_result_checker.sv @@
// Result checker: mirrors the height store and registers, predicts each query and compares.
`timescale 1ns / 100ps

module thi_result_checker
    import thi_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_item_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_item_t             m_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);

    localparam int STORE_DEPTH = VERTICES_PER_SIDE_DEF * VERTICES_PER_SIDE_DEF;

    logic signed [HEIGHT_W-1:0] heights_mirror [STORE_DEPTH];
    logic [CCNT_W-1:0]          across_q, down_q;
    logic [CSIZE_W-1:0]         width_q, height_q;
    out_item_t                  expected_results [$];

    function automatic longint corner_height(longint unsigned addr);
        if (addr < STORE_DEPTH) return longint'(heights_mirror[addr]);
        return 0;
    endfunction

    // Barycentric height of one query point under the current grid settings
    function automatic out_item_t interpolate_height(in_item_t w);
        out_item_t r;
        longint unsigned wq, hq, col, row, u, v, p, q, d, stride, base;
        longint tl, bl, tr, br, acc;
        logic lower;
        r = '{face_index: '0, height: '0, outside: 1'b1};
        if (across_q == 0 || down_q == 0 || width_q == 0 || height_q == 0) return r;
        wq  = longint'(width_q) << COORD_FRAC_BITS_DEF;
        hq  = longint'(height_q) << COORD_FRAC_BITS_DEF;
        col = w.query_x / wq;
        row = w.query_y / hq;
        if (col >= across_q || row >= down_q) return r;
        u = w.query_x - col * wq;
        v = w.query_y - row * hq;
        p = u * height_q;
        q = v * width_q;
        d = width_q * hq;
        lower  = (p + q) > d;
        stride = down_q + 1;
        base   = col * stride + row;
        tl = corner_height(base);
        bl = corner_height(base + 1);
        tr = corner_height(base + stride);
        br = corner_height(base + stride + 1);
        if (!lower)
            acc = tr * longint'(p) + bl * longint'(q) + tl * longint'(d - p - q);
        else
            acc = br * longint'(p + q - d) + bl * longint'(d - p) + tr * longint'(d - q);
        r.height     = HEIGHT_W'(acc / longint'(d));
        r.face_index = FACE_W'(2 * (col * down_q + row) + lower);
        r.outside    = 1'b0;
        return r;
    endfunction

    assign pending = expected_results.size();

    always @(posedge aclk) begin
        if (!aresetn) begin
            across_q   <= CELLS_ACROSS_RST;
            down_q     <= CELLS_DOWN_RST;
            width_q    <= CELL_WIDTH_RST;
            height_q   <= CELL_HEIGHT_RST;
            fail_count <= 0;
            expected_results.delete();
        end else begin
            // register writes must only land while idle; the user keeps to this, it is not enforced here
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CELLS_ACROSS: across_q <= cfg_data[CCNT_W-1:0];
                    REG_CELLS_DOWN:   down_q   <= cfg_data[CCNT_W-1:0];
                    REG_CELL_WIDTH:   width_q  <= cfg_data;
                    REG_CELL_HEIGHT:  height_q <= cfg_data;
                    default: ;
                endcase
            end
            // accepted input word: store a vertex or queue a prediction
            if (s_valid && s_ready) begin
                if (s_data.mode == MODE_WRITE)
                    heights_mirror[s_data.vertex_index] <= s_data.vertex_height;
                else
                    expected_results.insert(expected_results.size(),
                                            interpolate_height(s_data));
            end
            // accepted result word
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result word face=%0d height=%0d outside=%0d",
                           m_data.face_index, m_data.height, m_data.outside);
                    fail_count <= fail_count + 1;
                end else begin
                    automatic out_item_t e = expected_results.pop_front();
                    automatic int bad = 0;
                    if (m_data.face_index !== e.face_index) begin
                        $error("face_index expected %0d actual %0d",
                               e.face_index, m_data.face_index);
                        bad++;
                    end
                    if (m_data.height !== e.height) begin
                        $error("height expected %0d actual %0d", e.height, m_data.height);
                        bad++;
                    end
                    if (m_data.outside !== e.outside) begin
                        $error("outside expected %0d actual %0d", e.outside, m_data.outside);
                        bad++;
                    end
                    fail_count <= fail_count + bad;
                end
            end
        end
    end

endmodule

@@ tb/triangle_heightfield_interpolator_test.sv @@
// Testbench top: clock, reset, stimulus phases over several grid settings, and verdict.
`timescale 1ns / 100ps

module triangle_heightfield_interpolator_test;
    import thi_pkg::*;

    localparam int  CYCLE_LIMIT  = 1_500_000;
    localparam int  RANDOM_WORDS = 230;
    localparam int  SETTLE       = 100;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    fail_count, pending;

    // steady: no idling on either side
    logic steady = 1'b0;
    int   cycles = 0;
    int   queries_sent = 0, writes_sent = 0, reg_writes = 0;
    bit   written [4096];
    int   ca = 16, cd = 16, cw = 32, ch = 32;

    triangle_heightfield_interpolator dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    thi_result_checker result_chk (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .fail_count, .pending
    );

    always #5 aclk = ~aclk;

    // receiver stalls
    always @(negedge aclk) m_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 30);

    // run watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL triangle_heightfield_interpolator");
            $finish;
        end
    end

    // one input word, with random gaps ahead of it; valid stays up afterwards
    task automatic send_word(in_item_t w);
        @(negedge aclk);
        while (!steady && $urandom_range(0, 99) < 30) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        if (w.mode == MODE_WRITE) begin
            writes_sent++;
            written[w.vertex_index] = 1'b1;
        end else begin
            queries_sent++;
        end
    endtask

    task automatic put_vertex(int idx, int hgt);
        in_item_t w;
        w = '0;
        w.mode          = MODE_WRITE;
        w.vertex_index  = VIDX_W'(idx);
        w.vertex_height = HEIGHT_W'(hgt);
        w.query_x       = COORD_W'($urandom);
        w.query_y       = COORD_W'($urandom);
        send_word(w);
    endtask

    task automatic ask_point(int x, int y);
        in_item_t w;
        w = '0;
        w.mode          = MODE_QUERY;
        w.vertex_index  = VIDX_W'($urandom);
        w.vertex_height = HEIGHT_W'($urandom);
        w.query_x       = COORD_W'(x);
        w.query_y       = COORD_W'(y);
        send_word(w);
    endtask

    // drain: drop valid, wait for every result, then let the block settle
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, int val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    task automatic set_grid(int a, int b, int wdt, int hgt);
        set_reg(REG_CELLS_ACROSS, a);
        set_reg(REG_CELLS_DOWN, b);
        set_reg(REG_CELL_WIDTH, wdt);
        set_reg(REG_CELL_HEIGHT, hgt);
        ca = a & 6'h3F; cd = b & 6'h3F; cw = wdt; ch = hgt;
    endtask

    // every vertex the grid can reach gets a height before any query
    task automatic fill_grid();
        int last;
        last = ca * (cd + 1) + cd;
        for (int i = 0; i <= last && i < 4096; i++)
            if (!written[i]) put_vertex(i, int'($urandom));
    endtask

    // random traffic: mostly in-grid queries, some diagonal hits, writes and noise
    task automatic random_traffic(int count);
        int roll, gw, gh, col, row, k;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            gw = ca * cw * 256;
            gh = cd * ch * 256;
            if (roll < 20) begin
                put_vertex($urandom_range(0, 4095), int'($urandom));
            end else if (roll < 30 || gw == 0 || gh == 0) begin
                ask_point(int'($urandom) & 24'hFFFFFF, int'($urandom) & 24'hFFFFFF);
            end else if (roll < 38) begin
                col = $urandom_range(0, ca - 1);
                row = $urandom_range(0, cd - 1);
                k   = $urandom_range(0, 256);
                ask_point(col * cw * 256 + k * cw, row * ch * 256 + (256 - k) * ch);
            end else begin
                ask_point($urandom_range(0, gw - 1), $urandom_range(0, gh - 1));
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset grid, field extremes and the special cases
        fill_grid();
        put_vertex(0, 8388607);  put_vertex(1, 8388607);
        put_vertex(17, 8388607); put_vertex(18, 8388607);
        ask_point(0, 0);
        ask_point(100 * 256, 100 * 256);         // cell 3,3, away from the full-scale corners
        put_vertex(0, -8388608); put_vertex(1, -8388608);
        put_vertex(17, -8388608); put_vertex(18, -8388608);
        ask_point(16 * 256, 16 * 256);           // on the diagonal
        ask_point(16 * 256 + 1, 16 * 256);       // just past the diagonal
        ask_point(16 * 256 - 1, 16 * 256);       // just before it
        ask_point(8191, 8191);                   // last point of the first cell
        ask_point(512 * 256, 0);                 // right edge is outside
        ask_point(0, 512 * 256);                 // bottom edge is outside
        ask_point(24'hFFFFFF, 24'hFFFFFF);
        put_vertex(4095, 5);
        random_traffic(RANDOM_WORDS);
        drain();

        // widest cells, single row; long run without idling
        set_grid(63, 1, 1023, 1);
        fill_grid();
        steady = 1'b1;
        random_traffic(RANDOM_WORDS);
        steady = 1'b0;
        drain();

        // tallest cells, single column; cells_down data with spare high bits set
        set_grid(1, 10'h3C0 | 63, 1, 1023);
        fill_grid();
        random_traffic(RANDOM_WORDS);
        drain();

        // smallest grid
        set_grid(1, 1, 1, 1);
        fill_grid();
        ask_point(0, 0);
        ask_point(255, 0);
        ask_point(0, 255);
        random_traffic(RANDOM_WORDS / 2);
        drain();

        // a zero register: every query is outside
        set_grid(4, 4, 0, 8);
        random_traffic(30);
        drain();

        // odd sizes
        set_grid(7, 5, 3, 9);
        fill_grid();
        random_traffic(RANDOM_WORDS);
        drain();

        // random settings
        set_grid($urandom_range(1, 20), $urandom_range(1, 20),
                 $urandom_range(1, 1023), $urandom_range(1, 1023));
        fill_grid();
        random_traffic(RANDOM_WORDS);
        drain();

        $display("Covered %0d queries and %0d vertex writes over %0d register writes,",
                 queries_sent, writes_sent, reg_writes);
        $display("including diagonal, grid edge, zero register and full-scale heights.");
        if (fail_count == 0)
            $display("PASS triangle_heightfield_interpolator");
        else
            $display("FAIL triangle_heightfield_interpolator");
        $finish;
    end

endmodule
